// ===== rtl/edfts_pkg.sv =====
// shared constants and types for the edf periodic task scheduler
// no dependencies

package edfts_pkg;

    localparam int MAX_SLOTS = 16;
    localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int TIME_W    = 16;
    localparam int CFG_W     = 5;
    localparam int MASK_W    = 16;
    localparam int IDX_OUT_W = 4;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    localparam logic [2:0] TASK_COUNT_ADDR = 3'd0;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_FETCH  = 4'b0010,
        S_EVAL   = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    typedef struct packed {
        logic [TIME_W-1:0] remaining;
        logic [TIME_W-1:0] countdown;
        logic [TIME_W-1:0] exec_units;
        logic [TIME_W-1:0] period_ticks;
        logic              found;
        logic [TIME_W-1:0] best_countdown;
    } slot_in_t;

    typedef struct packed {
        logic [TIME_W-1:0] remaining;
        logic [TIME_W-1:0] countdown;
        logic [TIME_W-1:0] compare_countdown;
        logic              missed;
        logic              take;
    } slot_out_t;

endpackage

// ===== rtl/edfts_task_mem.sv =====
// execution time and period store, one write port and one registered read port
// uses edfts_pkg

module edfts_task_mem
(
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [edfts_pkg::SLOT_W-1:0]    wr_addr,
    input  logic [edfts_pkg::TIME_W-1:0]    wr_exec,
    input  logic [edfts_pkg::TIME_W-1:0]    wr_period,
    input  logic [edfts_pkg::SLOT_W-1:0]    rd_addr,
    output logic [edfts_pkg::TIME_W-1:0]    rd_exec,
    output logic [edfts_pkg::TIME_W-1:0]    rd_period
);

    logic [edfts_pkg::TIME_W-1:0] exec_mem   [edfts_pkg::MAX_SLOTS];
    logic [edfts_pkg::TIME_W-1:0] period_mem [edfts_pkg::MAX_SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            exec_mem[wr_addr]   <= wr_exec;
            period_mem[wr_addr] <= wr_period;
        end
        rd_exec   <= exec_mem[rd_addr];
        rd_period <= period_mem[rd_addr];
    end

endmodule

// ===== rtl/edfts_slot_unit.sv =====
// shared per-slot unit: release, deadline compare and countdown decrement
// uses edfts_pkg

module edfts_slot_unit
(
    input  edfts_pkg::slot_in_t  slot_in,
    output edfts_pkg::slot_out_t slot_out
);

    logic                          released;
    logic [edfts_pkg::TIME_W-1:0]  rem_rel;
    logic [edfts_pkg::TIME_W-1:0]  cd_rel;

    always_comb
    begin
        released = (slot_in.countdown == '0);
        rem_rel  = released ? slot_in.exec_units : slot_in.remaining;
        cd_rel   = released ? slot_in.period_ticks : slot_in.countdown;

        slot_out.remaining         = rem_rel;
        slot_out.compare_countdown = cd_rel;
        slot_out.countdown         = (cd_rel != '0) ? cd_rel - 1'b1 : cd_rel;
        slot_out.missed            = released && (slot_in.remaining != '0);
        slot_out.take              = (rem_rel != '0) &&
                                     (!slot_in.found || (cd_rel < slot_in.best_countdown));
    end

endmodule

// ===== rtl/edf_periodic_task_scheduler.sv =====
// edf periodic task scheduler top level: sequencer, run state and apb register
// a load is written to the task store when accepted and leaves the input ready; a tick
// scans n = min(task_count, 16) slots, one memory read and one pass of the shared slot unit
// per slot, and the input stays busy until the result is registered, which waits on m_tready
// reset: asynchronous active low, clears run state and task_count; task store not cleared
// uses edfts_pkg, edfts_task_mem, edfts_slot_unit

module edf_periodic_task_scheduler
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // task_index[3:0], exec_units[19:4], period_ticks[35:20]
    input  logic        s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // running_task[3:0], missed_mask[19:4]
    output logic        m_tuser,   // idle
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int SW   = edfts_pkg::SLOT_W;
    localparam int CW   = edfts_pkg::CNT_W;
    localparam int TW   = edfts_pkg::TIME_W;
    localparam int MW   = edfts_pkg::MASK_W;
    localparam int IDXW = edfts_pkg::IDX_OUT_W;

    edfts_pkg::state_t state_reg, state_next;

    logic [edfts_pkg::CFG_W-1:0] task_count_reg;
    logic [CW-1:0]               active_n;
    logic [CW-1:0]               scan_reg, scan_next;
    logic                        found_reg, found_next;
    logic [SW-1:0]               best_reg, best_next;
    logic [TW-1:0]               best_cd_reg, best_cd_next;
    logic [MW-1:0]               missed_reg, missed_next;

    logic                        out_valid_reg, out_valid_next;
    logic [IDXW-1:0]             out_task_reg, out_task_next;
    logic                        out_idle_reg, out_idle_next;
    logic [MW-1:0]               out_missed_reg, out_missed_next;

    logic [TW-1:0] rem_reg [edfts_pkg::MAX_SLOTS];
    logic [TW-1:0] cd_reg  [edfts_pkg::MAX_SLOTS];

    logic                  in_fire;
    logic                  load_fire;
    logic                  tick_fire;
    logic                  cfg_write;
    logic                  cfg_sel;
    logic                  out_free;
    logic                  finish_go;
    logic [SW-1:0]         scan_idx;
    logic [TW-1:0]         mem_exec;
    logic [TW-1:0]         mem_period;
    logic [SW+IDXW-1:0]    best_ext;
    logic [CW-1:0]         scan_inc;

    edfts_pkg::slot_in_t   unit_in;
    edfts_pkg::slot_out_t  unit_out;

    assign s_tready  = (state_reg == edfts_pkg::S_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign load_fire = in_fire && (s_tuser == edfts_pkg::CMD_LOAD);
    assign tick_fire = in_fire && (s_tuser == edfts_pkg::CMD_TICK);
    assign pready    = 1'b1;
    assign cfg_sel   = (paddr[2] == edfts_pkg::TASK_COUNT_ADDR[2]);
    assign cfg_write = psel && penable && pwrite && pready && cfg_sel;
    assign prdata    = cfg_sel ? {{(32-edfts_pkg::CFG_W){1'b0}}, task_count_reg} : 32'd0;

    assign active_n  = (task_count_reg > edfts_pkg::CFG_W'(edfts_pkg::MAX_SLOTS)) ?
                       CW'(edfts_pkg::MAX_SLOTS) : CW'(task_count_reg);
    assign scan_idx  = scan_reg[SW-1:0];
    assign scan_inc  = scan_reg + 1'b1;
    assign out_free  = !out_valid_reg || m_tready;
    assign finish_go = (state_reg == edfts_pkg::S_FINISH) && out_free;
    assign best_ext  = {{IDXW{1'b0}}, best_reg};

    edfts_task_mem u_mem
    (
        .clk       (clk),
        .wr_en     (load_fire),
        .wr_addr   (s_tdata[SW-1:0]),
        .wr_exec   (s_tdata[19:4]),
        .wr_period (s_tdata[35:20]),
        .rd_addr   (scan_idx),
        .rd_exec   (mem_exec),
        .rd_period (mem_period)
    );

    always_comb
    begin
        unit_in.remaining      = rem_reg[scan_idx];
        unit_in.countdown      = cd_reg[scan_idx];
        unit_in.exec_units     = mem_exec;
        unit_in.period_ticks   = mem_period;
        unit_in.found          = found_reg;
        unit_in.best_countdown = best_cd_reg;
    end

    edfts_slot_unit u_unit
    (
        .slot_in  (unit_in),
        .slot_out (unit_out)
    );

    always_comb
    begin
        state_next      = state_reg;
        scan_next       = scan_reg;
        found_next      = found_reg;
        best_next       = best_reg;
        best_cd_next    = best_cd_reg;
        missed_next     = missed_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_task_next   = out_task_reg;
        out_idle_next   = out_idle_reg;
        out_missed_next = out_missed_reg;

        unique case (state_reg)
            edfts_pkg::S_IDLE:
            begin
                if (tick_fire)
                begin
                    scan_next   = '0;
                    found_next  = 1'b0;
                    best_next   = '0;
                    missed_next = '0;
                    state_next  = (active_n == '0) ? edfts_pkg::S_FINISH : edfts_pkg::S_FETCH;
                end
            end
            edfts_pkg::S_FETCH:
            begin
                state_next = edfts_pkg::S_EVAL;
            end
            edfts_pkg::S_EVAL:
            begin
                if (unit_out.missed && (scan_reg < CW'(MW)))
                begin
                    missed_next = missed_reg | (MW'(1) << scan_reg);
                end
                if (unit_out.take)
                begin
                    found_next   = 1'b1;
                    best_next    = scan_idx;
                    best_cd_next = unit_out.compare_countdown;
                end
                scan_next  = scan_inc;
                state_next = (scan_inc == active_n) ? edfts_pkg::S_FINISH : edfts_pkg::S_FETCH;
            end
            edfts_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_task_next   = found_reg ? best_ext[IDXW-1:0] : '0;
                    out_idle_next   = !found_reg;
                    out_missed_next = missed_reg;
                    state_next      = edfts_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = edfts_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= edfts_pkg::S_IDLE;
            task_count_reg <= '0;
            out_valid_reg  <= 1'b0;
            scan_reg       <= '0;
            found_reg      <= 1'b0;
            for (int i = 0; i < edfts_pkg::MAX_SLOTS; i++)
            begin
                rem_reg[i] <= '0;
                cd_reg[i]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            scan_reg      <= scan_next;
            found_reg     <= found_next;
            if (cfg_write)
            begin
                task_count_reg <= pwdata[edfts_pkg::CFG_W-1:0];
            end
            if (load_fire)
            begin
                rem_reg[s_tdata[SW-1:0]] <= '0;
                cd_reg[s_tdata[SW-1:0]]  <= '0;
            end
            if (state_reg == edfts_pkg::S_EVAL)
            begin
                rem_reg[scan_idx] <= unit_out.remaining;
                cd_reg[scan_idx]  <= unit_out.countdown;
            end
            if (finish_go && found_reg)
            begin
                rem_reg[best_reg] <= rem_reg[best_reg] - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg       <= best_next;
        best_cd_reg    <= best_cd_next;
        missed_reg     <= missed_next;
        out_task_reg   <= out_task_next;
        out_idle_reg   <= out_idle_next;
        out_missed_reg <= out_missed_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_missed_reg, out_task_reg};
    assign m_tuser  = out_idle_reg;

endmodule

// ===== rtl/edfts_checker.sv =====
// port-level checker for the edf periodic task scheduler, bound to the top level
// uses only the top level's ports

module edfts_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);

    // a tick transaction starts a scan, so the input side goes busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tuser) |=> !s_tready)
        else $error("input still ready after tick transaction");

    // a load transaction leaves the input ready in the following cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser) |=> s_tready)
        else $error("input not ready after load transaction");

    // idle result reports slot zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[3:0] == 4'd0))
        else $error("idle result with nonzero running task");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // task_count readback follows the last write
    assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && !paddr[2]) |=>
        (paddr[2] || (prdata[4:0] == $past(pwdata[4:0]))))
        else $error("task_count readback mismatch");

endmodule

bind edf_periodic_task_scheduler edfts_checker u_edfts_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
);

// ===== tb/edf_periodic_task_scheduler_checker.sv =====
// scoreboard for the edf periodic task scheduler: watches the stream and apb ports,
// predicts every tick outcome from its own copy of the task table and compares
// depends on edfts_pkg

module edf_periodic_task_scheduler_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // task_index[3:0], exec_units[19:4], period_ticks[35:20]
    input  logic        s_tuser,   // command
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // running_task[3:0], missed_mask[19:4]
    input  logic        m_tuser,   // idle
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          error_count,
    output int          outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_CAP = 200;

    typedef struct packed {
        logic [edfts_pkg::IDX_OUT_W-1:0] running_task;
        logic                            idle;
        logic [edfts_pkg::MASK_W-1:0]    missed_mask;
    } tick_outcome_t;

    logic [edfts_pkg::TIME_W-1:0] exec_tab   [edfts_pkg::MAX_SLOTS];
    logic [edfts_pkg::TIME_W-1:0] period_tab [edfts_pkg::MAX_SLOTS];
    logic [edfts_pkg::TIME_W-1:0] work_left  [edfts_pkg::MAX_SLOTS];
    logic [edfts_pkg::TIME_W-1:0] countdown  [edfts_pkg::MAX_SLOTS];
    logic [edfts_pkg::CFG_W-1:0]  task_count_reg;

    tick_outcome_t schedule_q [$];
    int            errs = 0;

    task automatic flag_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            errs++;
            if (errs <= REPORT_CAP)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
            else if (errs == REPORT_CAP + 1)
                $display("%0t: further mismatches not reported", $time);
        end
    endtask

    // release, pick the earliest deadline, run it for one unit, then count down
    task automatic step_schedule(output tick_outcome_t res);
        int                           n;
        int                           best;
        logic [edfts_pkg::TIME_W-1:0] best_cd;
        bit                           found;
        res     = '0;
        found   = 1'b0;
        best    = 0;
        best_cd = '0;
        n = (task_count_reg > edfts_pkg::MAX_SLOTS) ? edfts_pkg::MAX_SLOTS :
            int'(task_count_reg);
        for (int i = 0; i < n; i++)
        begin
            if (countdown[i] == '0)
            begin
                if (work_left[i] != '0)
                    res.missed_mask[i] = 1'b1;
                work_left[i] = exec_tab[i];
                countdown[i] = period_tab[i];
            end
        end
        for (int i = 0; i < n; i++)
        begin
            if (work_left[i] != '0 && (!found || countdown[i] < best_cd))
            begin
                found   = 1'b1;
                best    = i;
                best_cd = countdown[i];
            end
        end
        if (found)
            work_left[best] = work_left[best] - 1'b1;
        for (int i = 0; i < n; i++)
        begin
            if (countdown[i] != '0)
                countdown[i] = countdown[i] - 1'b1;
        end
        res.running_task = found ? best[edfts_pkg::IDX_OUT_W-1:0] : '0;
        res.idle         = !found;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tick_outcome_t                want;
        tick_outcome_t                got;
        logic [edfts_pkg::SLOT_W-1:0] slot;
        if (!rst_n)
        begin
            schedule_q.delete();
            task_count_reg = '0;
            for (int i = 0; i < edfts_pkg::MAX_SLOTS; i++)
            begin
                work_left[i] = '0;
                countdown[i] = '0;
            end
            outstanding <= 0;
            error_count <= errs;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.running_task = m_tdata[3:0];
                got.missed_mask  = m_tdata[19:4];
                got.idle         = m_tuser;
                if (schedule_q.size() == 0)
                    flag_mismatch("unexpected transaction, data", 32'hFFFF_FFFF,
                                  {11'd0, got});
                else
                begin
                    want = schedule_q.pop_front();
                    flag_mismatch("running_task", 32'(want.running_task),
                                  32'(got.running_task));
                    flag_mismatch("idle", 32'(want.idle), 32'(got.idle));
                    flag_mismatch("missed_mask", 32'(want.missed_mask),
                                  32'(got.missed_mask));
                end
            end
            if (psel && penable && pready && paddr == edfts_pkg::TASK_COUNT_ADDR)
            begin
                if (pwrite)
                    task_count_reg = pwdata[edfts_pkg::CFG_W-1:0];
                else
                    flag_mismatch("task_count readback", {27'd0, task_count_reg}, prdata);
            end
            if (s_tvalid && s_tready)
            begin
                if (s_tuser == edfts_pkg::CMD_LOAD)
                begin
                    slot = s_tdata[3:0];
                    if (int'(slot) < edfts_pkg::MAX_SLOTS)
                    begin
                        exec_tab[slot]   = s_tdata[19:4];
                        period_tab[slot] = s_tdata[35:20];
                        work_left[slot]  = '0;
                        countdown[slot]  = '0;
                    end
                end
                else
                begin
                    step_schedule(want);
                    schedule_q.push_back(want);
                end
            end
            outstanding <= schedule_q.size();
            error_count <= errs;
        end
    end

endmodule

// ===== tb/edf_periodic_task_scheduler_tb.sv =====
// testbench top for the edf periodic task scheduler: clock, reset, apb and stream stimulus
// with gaps, stalls and a long output hold; verdict from the checker's mismatch and outstanding counts
// depends on edfts_pkg, edf_periodic_task_scheduler, edf_periodic_task_scheduler_checker

module edf_periodic_task_scheduler_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         PHASES          = 10;
    localparam int         PHASE_ITEMS     = 178;
    localparam int         SETTLE_CYCLES   = 40;
    localparam int         HOLD_CYCLES     = 400;
    localparam int         CYCLE_LIMIT     = 1000000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int error_count;
    int outstanding;
    int gap_pct    = 0;
    int stall_pct  = 0;
    int hold_asks  = 0;
    int hold_seen  = 0;
    int hold_left  = 0;
    int cycles     = 0;
    int loads_sent = 0;
    int ticks_sent = 0;

    edf_periodic_task_scheduler i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    edf_periodic_task_scheduler_checker i_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .error_count (error_count),
        .outstanding (outstanding)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending", cycles, outstanding);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // output side: random stalls plus one long hold
    always @(negedge clk)
    begin
        if (hold_asks != hold_seen)
        begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    function automatic logic [39:0] pack_task(input logic [3:0] idx, input logic [15:0] ex,
                                              input logic [15:0] per);
        return {4'd0, per, ex, idx};
    endfunction

    task automatic send_item(input logic cmd, input logic [39:0] data);
        int gap;
        gap = 0;
        if (gap_pct != 0 && $urandom_range(99) < gap_pct)
            gap = $urandom_range(1, 4);
        @(negedge clk);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (cmd == edfts_pkg::CMD_LOAD)
            loads_sent++;
        else
            ticks_sent++;
    endtask

    task automatic send_tick();
        send_item(edfts_pkg::CMD_TICK, pack_task(4'($urandom), 16'($urandom), 16'($urandom)));
    endtask

    task automatic send_random_load(input logic [3:0] idx);
        logic [15:0] ex;
        logic [15:0] per;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            ex  = 16'($urandom_range(1, 6));
            per = 16'($urandom_range(1, 24));
        end
        else if (pick < 80)
        begin
            ex  = 16'($urandom_range(1, 12));
            per = ex;
        end
        else if (pick < 84)
        begin
            ex  = '0;
            per = 16'($urandom_range(0, 8));
        end
        else if (pick < 88)
        begin
            ex  = 16'($urandom_range(1, 4));
            per = '0;
        end
        else
        begin
            ex  = 16'($urandom);
            per = 16'($urandom);
        end
        send_item(edfts_pkg::CMD_LOAD, pack_task(idx, ex, per));
    endtask

    // stop offering and wait for the pipeline to empty
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= edfts_pkg::TASK_COUNT_ADDR;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_task_count(input int count);
        apb_access(1'b1, ($urandom & 32'hFFFF_FFE0) | count[edfts_pkg::CFG_W-1:0]);
        apb_access(1'b0, '0);
    endtask

    initial
    begin
        int settings [PHASES];
        int n;
        int mode;
        settings = '{16, 0, 1, 16, 7, 31, 2, 16, 12, 17};
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = edfts_pkg::CMD_TICK;
        m_tready = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: fill every slot, extremes and zero cases first
        send_item(edfts_pkg::CMD_LOAD, pack_task(4'd0, 16'd1, 16'd1));
        send_item(edfts_pkg::CMD_LOAD, pack_task(4'd1, 16'hFFFF, 16'hFFFF));
        send_item(edfts_pkg::CMD_LOAD, pack_task(4'd2, 16'd0, 16'd5));
        send_item(edfts_pkg::CMD_LOAD, pack_task(4'd3, 16'd2, 16'd0));
        for (int i = 4; i < edfts_pkg::MAX_SLOTS; i++)
            send_item(edfts_pkg::CMD_LOAD, pack_task(i[3:0], 16'(i % 3 + 1), 16'(i + 2)));
        drain();
        set_task_count(edfts_pkg::MAX_SLOTS);
        repeat (5) send_tick();
        send_item(edfts_pkg::CMD_LOAD, pack_task(4'd3, 16'd2, 16'd6));
        repeat (3) send_tick();

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            mode      = p % 4;
            gap_pct   = (mode == 1) ? 73 : (mode == 3) ? 35 : 0;
            stall_pct = (mode == 2) ? 73 : (mode == 3) ? 35 : 0;
            set_task_count(settings[p]);
            n = (settings[p] > edfts_pkg::MAX_SLOTS) ? edfts_pkg::MAX_SLOTS : settings[p];
            for (int i = 0; i < n; i++)
                send_random_load(i[3:0]);
            for (int k = n; k < PHASE_ITEMS; k++)
            begin
                if (p == 0 && k == 40)
                    hold_asks++;
                if (k == PHASE_ITEMS / 2)
                    drain();
                if ($urandom_range(99) < 15)
                    send_random_load(4'($urandom_range(0, edfts_pkg::MAX_SLOTS - 1)));
                else
                    send_tick();
            end
        end
        drain();

        $display("run covered %0d loads and %0d ticks over %0d task_count settings,",
                 loads_sent, ticks_sent, PHASES + 1);
        $display("with input gaps, output stalls, a long output hold and %0d mismatches",
                 error_count);
        if (error_count == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
